### rtl/crc8cf_pkg.sv
// Shared types, link constants and the CRC-8 byte update for the command framer.
// Depends on nothing; every other file in rtl refers to it by scoped names.
package crc8cf_pkg;

    localparam logic [7:0] FRAME_MARK  = 8'h55;
    localparam logic [7:0] REPLY_MARK  = 8'hAA;
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] CRC_INIT    = 8'hFF;
    localparam logic [7:0] CRC_TOP     = 8'h80;
    localparam logic [7:0] STATUS_GOOD = 8'h00;

    // Results one item can raise, and result queue depth
    localparam int MAX_RES   = 4;
    localparam int QDEPTH    = 8;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int RESCNT_W  = $clog2(MAX_RES + 1);

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_PAYLOAD = 2'd1,
        REQ_REPLY   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_VERDICT = 2'd1,
        KIND_SEQ_ERR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_DEV_ERR  = 2'd1,
        VERDICT_BAD_MARK = 2'd2,
        VERDICT_BAD_CRC  = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        RCNT_NONE  = 2'd0,
        RCNT_FIRST = 2'd1,
        RCNT_TWO   = 2'd2
    } rcnt_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic        end_of_run;
        logic        frame_done;
        logic [7:0]  reply_status;
        verdict_t    verdict;
    } link_res_t;

    typedef struct packed {
        logic [RESCNT_W-1:0]          count;
        link_res_t [MAX_RES-1:0]      res;
    } bundle_t;

    // CRC-8, MSB first, one byte folded into the running value
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 8'h00)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic link_res_t make_result(input kind_t kind, input logic [7:0] tx,
                                              input logic done, input logic [7:0] status,
                                              input verdict_t verdict);
        link_res_t r;
        r.kind         = kind;
        r.tx_byte      = tx;
        r.end_of_run   = 1'b0;
        r.frame_done   = done;
        r.reply_status = status;
        r.verdict      = verdict;
        return r;
    endfunction

endpackage

### rtl/crc8cf_core.sv
// Input register, frame and reply state, and the single-pass result bundle builder.
// Depends on crc8cf_pkg for types, constants and the CRC-8 update.
module crc8cf_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            req_type,
    input  logic [7:0]            command_code,
    input  logic [7:0]            payload_length,
    input  logic [7:0]            data_byte,
    output crc8cf_pkg::bundle_t   bundle
);

    logic                item_valid_reg;
    logic [1:0]          req_reg;
    logic [7:0]          cmd_reg;
    logic [7:0]          len_reg;
    logic [7:0]          data_reg;

    logic [7:0]          crc_reg,        crc_next;
    logic [7:0]          left_reg,       left_next;
    logic                open_reg,       open_next;
    crc8cf_pkg::rcnt_t   rcnt_reg,       rcnt_next;
    logic [7:0]          first_reg,      first_next;
    logic [7:0]          second_reg,     second_next;
    logic [7:0]          expect_reg,     expect_next;

    logic [7:0]          hdr_crc;
    logic [7:0]          pay_crc;
    logic [7:0]          left_dec;
    crc8cf_pkg::verdict_t verdict;
    crc8cf_pkg::bundle_t b;

    // Register the accepted beat and its valid flag for the result bundle builder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            cmd_reg  <= command_code;
            len_reg  <= payload_length;
            data_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= crc8cf_pkg::CRC_INIT;
            left_reg   <= 8'h00;
            open_reg   <= 1'b0;
            rcnt_reg   <= crc8cf_pkg::RCNT_NONE;
            first_reg  <= 8'h00;
            second_reg <= 8'h00;
            expect_reg <= 8'h00;
        end
        else
        begin
            crc_reg    <= crc_next;
            left_reg   <= left_next;
            open_reg   <= open_next;
            rcnt_reg   <= rcnt_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            expect_reg <= expect_next;
        end
    end

    assign hdr_crc  = crc8cf_pkg::crc8_feed(crc8cf_pkg::crc8_feed(crc8cf_pkg::CRC_INIT, cmd_reg),
                                            len_reg);
    assign pay_crc  = crc8cf_pkg::crc8_feed(crc_reg, data_reg);
    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        if (first_reg != crc8cf_pkg::REPLY_MARK)
            verdict = crc8cf_pkg::VERDICT_BAD_MARK;
        else if (data_reg != expect_reg)
            verdict = crc8cf_pkg::VERDICT_BAD_CRC;
        else if (second_reg != crc8cf_pkg::STATUS_GOOD)
            verdict = crc8cf_pkg::VERDICT_DEV_ERR;
        else
            verdict = crc8cf_pkg::VERDICT_OK;
    end

    always_comb
    begin
        crc_next    = crc_reg;
        left_next   = left_reg;
        open_next   = open_reg;
        rcnt_next   = rcnt_reg;
        first_next  = first_reg;
        second_next = second_reg;
        expect_next = expect_reg;
        b.count     = '0;
        for (int i = 0; i < crc8cf_pkg::MAX_RES; i++)
            b.res[i] = crc8cf_pkg::make_result(crc8cf_pkg::KIND_TX, 8'h00, 1'b0, 8'h00,
                                               crc8cf_pkg::VERDICT_OK);

        if (item_valid_reg)
        begin
            unique case (req_reg)
                crc8cf_pkg::REQ_START:
                begin
                    if (open_reg)
                    begin
                        open_next  = 1'b0;
                        left_next  = 8'h00;
                        crc_next   = crc8cf_pkg::CRC_INIT;
                        b.count    = crc8cf_pkg::RESCNT_W'(1);
                        b.res[0]   = crc8cf_pkg::make_result(crc8cf_pkg::KIND_SEQ_ERR, 8'h00,
                                         1'b0, 8'h00, crc8cf_pkg::VERDICT_OK);
                    end
                    else
                    begin
                        b.res[0] = crc8cf_pkg::make_result(crc8cf_pkg::KIND_TX,
                                       crc8cf_pkg::FRAME_MARK, 1'b0, 8'h00,
                                       crc8cf_pkg::VERDICT_OK);
                        b.res[1] = crc8cf_pkg::make_result(crc8cf_pkg::KIND_TX, cmd_reg,
                                       1'b0, 8'h00, crc8cf_pkg::VERDICT_OK);
                        b.res[2] = crc8cf_pkg::make_result(crc8cf_pkg::KIND_TX, len_reg,
                                       1'b0, 8'h00, crc8cf_pkg::VERDICT_OK);
                        if (len_reg == 8'h00)
                        begin
                            b.count  = crc8cf_pkg::RESCNT_W'(4);
                            b.res[3] = crc8cf_pkg::make_result(crc8cf_pkg::KIND_TX, hdr_crc,
                                           1'b1, 8'h00, crc8cf_pkg::VERDICT_OK);
                            crc_next = crc8cf_pkg::CRC_INIT;
                        end
                        else
                        begin
                            b.count   = crc8cf_pkg::RESCNT_W'(3);
                            crc_next  = hdr_crc;
                            left_next = len_reg;
                            open_next = 1'b1;
                        end
                    end
                end
                crc8cf_pkg::REQ_PAYLOAD:
                begin
                    if (!open_reg)
                    begin
                        b.count  = crc8cf_pkg::RESCNT_W'(1);
                        b.res[0] = crc8cf_pkg::make_result(crc8cf_pkg::KIND_SEQ_ERR, 8'h00,
                                       1'b0, 8'h00, crc8cf_pkg::VERDICT_OK);
                    end
                    else
                    begin
                        b.res[0]  = crc8cf_pkg::make_result(crc8cf_pkg::KIND_TX, data_reg,
                                        1'b0, 8'h00, crc8cf_pkg::VERDICT_OK);
                        left_next = left_dec;
                        if (left_dec == 8'h00)
                        begin
                            b.count   = crc8cf_pkg::RESCNT_W'(2);
                            b.res[1]  = crc8cf_pkg::make_result(crc8cf_pkg::KIND_TX, pay_crc,
                                            1'b1, 8'h00, crc8cf_pkg::VERDICT_OK);
                            crc_next  = crc8cf_pkg::CRC_INIT;
                            open_next = 1'b0;
                        end
                        else
                        begin
                            b.count  = crc8cf_pkg::RESCNT_W'(1);
                            crc_next = pay_crc;
                        end
                    end
                end
                crc8cf_pkg::REQ_REPLY:
                begin
                    unique case (rcnt_reg)
                        crc8cf_pkg::RCNT_NONE:
                        begin
                            first_next = data_reg;
                            rcnt_next  = crc8cf_pkg::RCNT_FIRST;
                        end
                        crc8cf_pkg::RCNT_FIRST:
                        begin
                            second_next = data_reg;
                            expect_next = crc8cf_pkg::crc8_feed(crc8cf_pkg::CRC_INIT, data_reg);
                            rcnt_next   = crc8cf_pkg::RCNT_TWO;
                        end
                        default:
                        begin
                            b.count   = crc8cf_pkg::RESCNT_W'(1);
                            b.res[0]  = crc8cf_pkg::make_result(crc8cf_pkg::KIND_VERDICT, 8'h00,
                                            1'b0, second_reg, verdict);
                            rcnt_next = crc8cf_pkg::RCNT_NONE;
                        end
                    endcase
                end
                default:
                begin
                    b.count  = crc8cf_pkg::RESCNT_W'(1);
                    b.res[0] = crc8cf_pkg::make_result(crc8cf_pkg::KIND_SEQ_ERR, 8'h00,
                                   1'b0, 8'h00, crc8cf_pkg::VERDICT_OK);
                end
            endcase
        end

        // Mark the last result of the run
        for (int i = 0; i < crc8cf_pkg::MAX_RES; i++)
        begin
            if (b.count == crc8cf_pkg::RESCNT_W'(i + 1))
                b.res[i].end_of_run = 1'b1;
        end
    end

    assign bundle = b;

endmodule

### rtl/crc8cf_outq.sv
// Result queue: takes a bundle of up to four results per cycle, gives one per beat.
// Depends on crc8cf_pkg for the result and bundle types and the queue depth.
module crc8cf_outq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  crc8cf_pkg::bundle_t                 bundle,
    input  logic                                pop,
    output crc8cf_pkg::link_res_t               head,
    output logic [crc8cf_pkg::QCNT_W-1:0]       count
);

    crc8cf_pkg::link_res_t              entry_reg [crc8cf_pkg::QDEPTH];
    logic [crc8cf_pkg::QPTR_W-1:0]      wr_reg, wr_next;
    logic [crc8cf_pkg::QPTR_W-1:0]      rd_reg, rd_next;
    logic [crc8cf_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < crc8cf_pkg::MAX_RES; i++)
        begin
            if (crc8cf_pkg::RESCNT_W'(i) < bundle.count)
                entry_reg[wr_reg + crc8cf_pkg::QPTR_W'(i)] <= bundle.res[i];
        end
    end

    always_comb
    begin
        wr_next  = wr_reg + crc8cf_pkg::QPTR_W'(bundle.count);
        rd_next  = pop ? rd_reg + crc8cf_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + crc8cf_pkg::QCNT_W'(bundle.count)
                   - (pop ? crc8cf_pkg::QCNT_W'(1) : crc8cf_pkg::QCNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head  = entry_reg[rd_reg];
    assign count = cnt_reg;

endmodule

### rtl/crc8_command_framer_and_reply_checker.sv
// Command framer and reply checker: top level with the request and result ports.
// Depends on crc8cf_pkg, crc8cf_core and crc8cf_outq.
// Path: an accepted beat is registered in the core, its result bundle is written into
// the result queue, and the queue head drives res_*.
// Throughput: one request beat per cycle while the result queue has room; results leave
// at one per cycle while res_stall is low, and a start beat raises three or four link bytes.
// Reset (rst_n low, asynchronous): queue empty, no frame open, CRC back to 0xFF.
module crc8_command_framer_and_reply_checker (
    input  logic        clk,
    input  logic        rst_n,

    // Request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  command_code,
    input  logic [7:0]  payload_length,
    input  logic [7:0]  data_byte,

    // Result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  tx_byte,
    output logic        end_of_run,
    output logic        frame_done,
    output logic [7:0]  reply_status,
    output logic [1:0]  verdict
);

    crc8cf_pkg::bundle_t                  bundle;
    crc8cf_pkg::link_res_t                head;
    logic [crc8cf_pkg::QCNT_W-1:0]        q_count;
    logic [crc8cf_pkg::QCNT_W:0]          q_need;
    logic                                 accept;
    logic                                 pop;

    // Room check: results already queued, the bundle landing at the next edge, and the
    // worst case of the beat that would be taken now must all fit in the queue.
    // Pops are not counted in advance, so the check stays independent of res_stall.
    assign q_need    = (crc8cf_pkg::QCNT_W + 1)'(q_count)
                     + (crc8cf_pkg::QCNT_W + 1)'(bundle.count)
                     + (crc8cf_pkg::QCNT_W + 1)'(crc8cf_pkg::MAX_RES);
    assign req_stall = (q_need > (crc8cf_pkg::QCNT_W + 1)'(crc8cf_pkg::QDEPTH));
    assign accept    = req_valid && !req_stall;

    // Frame and reply state plus the per-beat result bundle
    crc8cf_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req_type       (req_type),
        .command_code   (command_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .bundle         (bundle)
    );

    // Drain one result per beat; the head entry is held while res_stall is high
    assign res_valid = (q_count != '0);
    assign pop       = res_valid && !res_stall;

    crc8cf_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .bundle (bundle),
        .pop    (pop),
        .head   (head),
        .count  (q_count)
    );

    assign result_kind  = head.kind;
    assign tx_byte      = head.tx_byte;
    assign end_of_run   = head.end_of_run;
    assign frame_done   = head.frame_done;
    assign reply_status = head.reply_status;
    assign verdict      = head.verdict;

endmodule

### tb/tb_crc8_command_framer_and_reply_checker.sv
// Self-checking bench for the CRC-8 command framer and reply checker: directed frames,
// replies and sequence errors, then random traffic under idling and result back-pressure.
// Depends on crc8cf_pkg and the crc8_command_framer_and_reply_checker top level.
module tb_crc8_command_framer_and_reply_checker;
    import crc8cf_pkg::*;

    // Request code outside the defined set: the block must answer with a sequence error
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_LIMIT    = 50000;
    // Quiet time after the drain; covers the input register, the queue and reply beats that raise nothing
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_TIME  = 400000;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int RANDOM_BEATS   = 16;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [7:0]  command_code;
    logic [7:0]  payload_length;
    logic [7:0]  data_byte;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic        end_of_run;
    logic        frame_done;
    logic [7:0]  reply_status;
    logic [1:0]  verdict;

    // Link results predicted but not yet seen on the result channel, oldest first
    link_res_t   link_results_due[$];
    link_res_t   oldest_due;
    int          error_count = 0;
    int          beats_sent = 0;

    // Idling knobs, read by the request tasks and the stall process
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    // Each increment asks the stall process for one counted hold-off
    int          holdoff_requests = 0;

    // Shadow state of the framer and reply checker
    logic [7:0]  frame_crc = CRC_INIT;
    logic [7:0]  payload_left = 8'h00;
    logic        frame_active = 1'b0;
    rcnt_t       reply_seen = RCNT_NONE;
    logic [7:0]  reply_head = 8'h00;
    logic [7:0]  reply_status_byte = 8'h00;

    crc8_command_framer_and_reply_checker u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .command_code   (command_code),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .result_kind    (result_kind),
        .tx_byte        (tx_byte),
        .end_of_run     (end_of_run),
        .frame_done     (frame_done),
        .reply_status   (reply_status),
        .verdict        (verdict)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // CRC-8, polynomial 0x31, MSB first: shift out the top bit and fold the polynomial
    // back in whenever it was set
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        logic       top;
        acc = crc ^ b;
        repeat (8)
        begin
            top = acc[7];
            acc = acc << 1;
            if (top)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    function automatic void queue_link_result(input kind_t kind, input logic [7:0] tx,
                                              input logic done, input logic [7:0] status,
                                              input verdict_t v);
        link_res_t r;
        r.kind         = kind;
        r.tx_byte      = tx;
        r.end_of_run   = 1'b0;
        r.frame_done   = done;
        r.reply_status = status;
        r.verdict      = v;
        link_results_due.push_back(r);
    endfunction

    // Advance the shadow state by one accepted request beat and queue what it raises
    function automatic void predict_link_results(input logic [1:0] req, input logic [7:0] cmd,
                                                 input logic [7:0] len, input logic [7:0] data);
        int         first_new;
        logic [7:0] header_crc;
        verdict_t   v;
        first_new = link_results_due.size();
        case (req)
            REQ_START:
            begin
                if (frame_active)
                begin
                    // Abandon the open frame; the start itself is dropped
                    frame_active = 1'b0;
                    payload_left = 8'h00;
                    frame_crc    = CRC_INIT;
                    queue_link_result(KIND_SEQ_ERR, 8'h00, 1'b0, 8'h00, VERDICT_OK);
                end
                else
                begin
                    header_crc = crc8_byte(crc8_byte(CRC_INIT, cmd), len);
                    queue_link_result(KIND_TX, FRAME_MARK, 1'b0, 8'h00, VERDICT_OK);
                    queue_link_result(KIND_TX, cmd, 1'b0, 8'h00, VERDICT_OK);
                    queue_link_result(KIND_TX, len, 1'b0, 8'h00, VERDICT_OK);
                    if (len == 8'h00)
                    begin
                        queue_link_result(KIND_TX, header_crc, 1'b1, 8'h00, VERDICT_OK);
                        frame_crc = CRC_INIT;
                    end
                    else
                    begin
                        frame_crc    = header_crc;
                        payload_left = len;
                        frame_active = 1'b1;
                    end
                end
            end
            REQ_PAYLOAD:
            begin
                if (!frame_active)
                begin
                    queue_link_result(KIND_SEQ_ERR, 8'h00, 1'b0, 8'h00, VERDICT_OK);
                end
                else
                begin
                    frame_crc = crc8_byte(frame_crc, data);
                    queue_link_result(KIND_TX, data, 1'b0, 8'h00, VERDICT_OK);
                    payload_left = payload_left - 8'd1;
                    if (payload_left == 8'h00)
                    begin
                        queue_link_result(KIND_TX, frame_crc, 1'b1, 8'h00, VERDICT_OK);
                        frame_crc    = CRC_INIT;
                        frame_active = 1'b0;
                    end
                end
            end
            REQ_REPLY:
            begin
                case (reply_seen)
                    RCNT_NONE:
                    begin
                        reply_head = data;
                        reply_seen = RCNT_FIRST;
                    end
                    RCNT_FIRST:
                    begin
                        reply_status_byte = data;
                        reply_seen        = RCNT_TWO;
                    end
                    default:
                    begin
                        if (reply_head != REPLY_MARK)
                            v = VERDICT_BAD_MARK;
                        else if (data != crc8_byte(CRC_INIT, reply_status_byte))
                            v = VERDICT_BAD_CRC;
                        else if (reply_status_byte != STATUS_GOOD)
                            v = VERDICT_DEV_ERR;
                        else
                            v = VERDICT_OK;
                        queue_link_result(KIND_VERDICT, 8'h00, 1'b0, reply_status_byte, v);
                        reply_seen = RCNT_NONE;
                    end
                endcase
            end
            default:
            begin
                queue_link_result(KIND_SEQ_ERR, 8'h00, 1'b0, 8'h00, VERDICT_OK);
            end
        endcase
        if (link_results_due.size() > first_new)
            link_results_due[link_results_due.size() - 1].end_of_run = 1'b1;
    endfunction

    // Offer one request beat. Entered just after a falling edge and left just after one,
    // with valid still high so that a following beat goes out back to back.
    task automatic offer_request(input logic [1:0] req, input logic [7:0] cmd,
                                 input logic [7:0] len, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid      = 1'b1;
        req_type       = req;
        command_code   = cmd;
        payload_length = len;
        data_byte      = data;
        // Stall is read before the edge's updates land; hold the beat until taken
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_link_results(req, cmd, len, data);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_payload(input logic [7:0] data);
        offer_request(REQ_PAYLOAD, 8'($urandom), 8'($urandom), data);
    endtask

    task automatic send_reply_byte(input logic [7:0] data);
        offer_request(REQ_REPLY, 8'($urandom), 8'($urandom), data);
    endtask

    task automatic send_reply(input logic [7:0] mark, input logic [7:0] status,
                              input logic [7:0] crc);
        send_reply_byte(mark);
        send_reply_byte(status);
        send_reply_byte(crc);
    endtask

    // Whole frame with random payload; close off a dangling frame first so the
    // start is not swallowed by the abandon path
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len);
        if (frame_active)
            offer_request(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom));
        offer_request(REQ_START, cmd, len, 8'($urandom));
        repeat (len)
            send_payload(8'($urandom));
    endtask

    // Drop valid, then wait for every predicted result and a few quiet cycles
    task automatic wait_for_drain();
        int waited;
        req_valid = 1'b0;
        waited = 0;
        while (link_results_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (link_results_due.size() != 0)
        begin
            $display("%0t: timed out with %0d link results still due", $time,
                     link_results_due.size());
            $display("tb_crc8_command_framer_and_reply_checker failed");
            $finish;
        end
        else
        begin
            repeat (SETTLE_CYCLES)
                @(negedge clk);
        end
    endtask

    // Header extremes in two zero-length frames, and a frame whose payload holds 0x00 and 0xFF
    task automatic test_frame_extremes();
        offer_request(REQ_START, 8'h00, 8'h00, 8'h00);
        offer_request(REQ_START, 8'hFF, 8'h00, 8'hFF);
        offer_request(REQ_START, 8'hA5, 8'h02, 8'h00);
        send_payload(8'h00);
        send_payload(8'hFF);
        wait_for_drain();
    endtask

    // Stray payload, abandon of an open frame by a new start, undefined request code
    task automatic test_sequence_errors();
        send_payload(8'h5A);
        offer_request(REQ_START, 8'h12, 8'h03, 8'h00);
        send_payload(8'h34);
        offer_request(REQ_START, 8'h56, 8'h01, 8'h00);
        offer_request(REQ_UNKNOWN, 8'hFF, 8'hFF, 8'hFF);
        wait_for_drain();
    endtask

    // One reply per verdict, with the priorities checked where two faults meet
    task automatic test_reply_verdicts();
        send_reply(REPLY_MARK, STATUS_GOOD, crc8_byte(CRC_INIT, STATUS_GOOD));
        send_reply(REPLY_MARK, 8'h05, crc8_byte(CRC_INIT, 8'h05));
        // Bad start byte wins over a bad CRC
        send_reply(8'h00, 8'hFF, ~crc8_byte(CRC_INIT, 8'hFF));
        // Bad CRC wins over a device error status
        send_reply(REPLY_MARK, 8'h80, crc8_byte(CRC_INIT, 8'h80) ^ 8'h01);
        wait_for_drain();
    endtask

    task automatic test_longest_frame();
        recv_stall_pct = 28;
        send_frame(8'h3C, 8'hFF);
        wait_for_drain();
        recv_stall_pct = 0;
    endtask

    // Hold the result side off for a long stretch while frames keep coming, so the
    // result queue fills and the request side has to stall
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_requests++;
        repeat (8)
            send_frame(8'($urandom), 8'd3);
        wait_for_drain();
    endtask

    // Mostly well-formed frames and replies with random content; the rest is noise:
    // stray payload, frames cut short, undefined codes and stray reply bytes
    task automatic test_random_traffic(input int beats, input int idle_pct, input int stall_pct);
        int         stop_at;
        int         pick;
        int         len;
        logic [7:0] status;
        logic [7:0] mark;
        logic [7:0] crc;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                len = ($urandom_range(29) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
                send_frame(8'($urandom), 8'(len));
            end
            else if (pick < 80)
            begin
                // Realign the reply checker with throwaway bytes before a proper reply
                while (reply_seen != RCNT_NONE)
                    send_reply_byte(8'($urandom));
                status = $urandom_range(1) ? STATUS_GOOD : 8'($urandom);
                mark   = ($urandom_range(9) == 0) ? 8'($urandom) : REPLY_MARK;
                crc    = ($urandom_range(9) == 0) ? 8'($urandom) : crc8_byte(CRC_INIT, status);
                send_reply(mark, status, crc);
            end
            else
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        send_payload(8'($urandom));
                    end
                    1:
                    begin
                        // Any length at all, left open for the next start to abandon
                        if (!frame_active)
                            offer_request(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom));
                        repeat ($urandom_range(0, 2))
                            if (frame_active && payload_left > 8'd1)
                                send_payload(8'($urandom));
                    end
                    2:
                    begin
                        offer_request(REQ_UNKNOWN, 8'($urandom), 8'($urandom), 8'($urandom));
                    end
                    default:
                    begin
                        send_reply_byte(8'($urandom));
                    end
                endcase
            end
        end
        wait_for_drain();
    endtask

    // Result side: random stalls, or a counted hold-off when one is pending
    initial
    begin
        int holdoff_served;
        int holdoff_left;
        holdoff_served = 0;
        holdoff_left   = 0;
        res_stall      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_requests != holdoff_served)
            begin
                holdoff_served = holdoff_requests;
                holdoff_left   = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                res_stall = 1'b1;
            end
            else
            begin
                res_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic void compare_field(input string name, input int due, input int seen);
        if (due != seen)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, due, seen);
        end
    endfunction

    // Check every result beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (link_results_due.size() == 0)
            begin
                error_count++;
                $display("%0t: result beat with nothing expected, expected none, %s %0h tx %0h",
                         $time, "actual kind", result_kind, tx_byte);
            end
            else
            begin
                oldest_due = link_results_due.pop_front();
                compare_field("result_kind", int'(oldest_due.kind), int'(result_kind));
                compare_field("tx_byte", int'(oldest_due.tx_byte), int'(tx_byte));
                compare_field("end_of_run", int'(oldest_due.end_of_run), int'(end_of_run));
                compare_field("frame_done", int'(oldest_due.frame_done), int'(frame_done));
                compare_field("reply_status", int'(oldest_due.reply_status),
                              int'(reply_status));
                compare_field("verdict", int'(oldest_due.verdict), int'(verdict));
            end
        end
    end

    initial
    begin
        #WATCHDOG_TIME;
        $display("%0t: watchdog expired", $time);
        $display("tb_crc8_command_framer_and_reply_checker failed");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_type       = REQ_START;
        command_code   = 8'h00;
        payload_length = 8'h00;
        data_byte      = 8'h00;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_frame_extremes();
        test_sequence_errors();
        test_reply_verdicts();
        test_longest_frame();
        test_result_backpressure();
        test_random_traffic(RANDOM_BEATS, 0, 0);
        test_random_traffic(RANDOM_BEATS, 64, 0);
        test_random_traffic(RANDOM_BEATS, 0, 64);
        test_random_traffic(RANDOM_BEATS, 28, 28);
        wait_for_drain();

        if (error_count == 0)
            $display("tb_crc8_command_framer_and_reply_checker passed");
        else
            $display("tb_crc8_command_framer_and_reply_checker failed");
        $finish;
    end

endmodule
